@@ sv/uvt_pkg.sv @@
// ----------------------------------------------------------------------------
// uvt_pkg
// Shared types and constants for the unordered value table.
// ----------------------------------------------------------------------------
package uvt_pkg;

    localparam int OPCODE_W  = 2;
    localparam int ITEM_W    = 32;
    localparam int CAP_W     = 7;
    localparam int STATUS_W  = 2;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } state_t;

    typedef struct packed {
        logic cmp;
        logic ins;
        logic del;
    } cell_ctrl_t;

endpackage

@@ sv/uvt_cell.sv @@
// ----------------------------------------------------------------------------
// uvt_cell
// One table slot: holds a value, compares it with the key and moves data
// to or from its neighbors on insert and delete.
// ----------------------------------------------------------------------------
module uvt_cell #(
    parameter int VW    = 32,
    parameter int CNT_W = 7,
    parameter int IDX   = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  uvt_pkg::cell_ctrl_t ctrl,
    input  logic [VW-1:0]       key,
    input  logic [CNT_W-1:0]    count,
    input  logic [VW-1:0]       prev_value,
    input  logic [VW-1:0]       next_value,
    input  logic                del_sel,
    output logic [VW-1:0]       value,
    output logic                match
);

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    logic [VW-1:0] value_reg;
    logic [VW-1:0] value_next;
    logic          match_reg;
    logic          match_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.ins)
        begin
            value_next = prev_value;
        end
        else if (ctrl.del && del_sel)
        begin
            value_next = next_value;
        end
    end

    always_comb
    begin
        match_next = match_reg;
        if (ctrl.cmp)
        begin
            match_next = (MY_IDX < count) && (value_reg == key);
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign value = value_reg;
    assign match = match_reg;

endmodule

@@ sv/unordered_value_table.sv @@
// ----------------------------------------------------------------------------
// unordered_value_table
// Fixed-capacity unordered table with insert, delete and search.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries opcode and item_value; output
//   channel (out_valid/out_stall) carries one result per input transfer.
//   cfg_wr_en/cfg_wr_data write the capacity register; write it only while
//   the block is idle. Capacity above DEPTH acts as DEPTH.
//   The result is registered when the update commits; an output stall holds it.
//   Each item passes a compare state, where each slot compares its value with
//   the key, then an update state, where the first-match prefix and the slot
//   update happen; a new item is taken only when idle or as an update commits.
//   Entries are kept packed in slots 0..count-1: insert shifts the row up,
//   delete shifts the slots above the first match down by one.
//   Reset empties the table and sets capacity to 64; no clearing pass.
//   While a result is stalled the next item may still be taken and compared,
//   but its update waits until the output register is free.
// ----------------------------------------------------------------------------
module unordered_value_table #(
    parameter int DEPTH       = 64,
    parameter int VALUE_WIDTH = 32,
    localparam int CNT_W      = $clog2(DEPTH + 1)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [uvt_pkg::CAP_W-1:0]      cfg_wr_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [uvt_pkg::OPCODE_W-1:0]   opcode,
    input  logic [uvt_pkg::ITEM_W-1:0]     item_value,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [uvt_pkg::STATUS_W-1:0]   status,
    output logic                           found,
    output logic [CNT_W-1:0]               count,
    output logic                           is_full,
    output logic                           is_empty
);

    localparam int CMP_W = (CNT_W > uvt_pkg::CAP_W) ? CNT_W : uvt_pkg::CAP_W;
    localparam int LVLS  = $clog2(DEPTH);

    uvt_pkg::state_t state_reg, state_next;

    logic [uvt_pkg::CAP_W-1:0]    cap_reg;
    logic [uvt_pkg::OPCODE_W-1:0] op_reg, op_next;
    logic [VALUE_WIDTH-1:0]       key_reg, key_next;
    logic [VALUE_WIDTH-1:0]       key_in;
    logic [CNT_W-1:0]             count_reg, count_next;

    logic                         out_valid_reg, out_valid_next;
    uvt_pkg::status_t             status_reg, status_next;
    logic                         found_reg, found_next;
    logic [CNT_W-1:0]             out_count_reg;
    logic                         is_full_reg, is_full_next;
    logic                         is_empty_reg, is_empty_next;

    logic                         accept;
    logic                         commit;
    logic                         present;
    logic                         can_insert;
    logic [CMP_W-1:0]             eff_cap;
    logic [CMP_W-1:0]             cap_ext;
    uvt_pkg::cell_ctrl_t          ctrl;
    logic [DEPTH-1:0]             match_vec;
    logic [DEPTH-1:0]             del_sel;
    logic [VALUE_WIDTH-1:0]       cell_val [DEPTH];

    generate
        if (VALUE_WIDTH <= uvt_pkg::ITEM_W)
        begin : g_key_narrow
            assign key_in = item_value[VALUE_WIDTH-1:0];
        end
        else
        begin : g_key_wide
            assign key_in = {{(VALUE_WIDTH - uvt_pkg::ITEM_W){1'b0}}, item_value};
        end
    endgenerate

    assign cap_ext = CMP_W'(cap_reg);
    assign eff_cap = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;

    assign present    = |match_vec;
    assign can_insert = CMP_W'(count_reg) < eff_cap;
    assign commit     = (state_reg == uvt_pkg::S_UPD) && (!out_valid_reg || !out_stall);
    assign in_stall   = !((state_reg == uvt_pkg::S_IDLE) || commit);
    assign accept     = in_valid && !in_stall;

    // first-match prefix: del_sel[i] set for every slot at or above the first match
    always_comb
    begin
        del_sel = match_vec;
        for (int l = 0; l < LVLS; l++)
        begin
            del_sel = del_sel | (del_sel << (1 << l));
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            uvt_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = uvt_pkg::S_CMP;
                end
            end
            uvt_pkg::S_CMP:
            begin
                state_next = uvt_pkg::S_UPD;
            end
            uvt_pkg::S_UPD:
            begin
                if (commit)
                begin
                    state_next = accept ? uvt_pkg::S_CMP : uvt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = uvt_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        op_next       = op_reg;
        key_next      = key_reg;
        count_next    = count_reg;
        ctrl          = '0;
        ctrl.cmp      = (state_reg == uvt_pkg::S_CMP);
        status_next   = status_reg;
        found_next    = found_reg;
        if (accept)
        begin
            op_next  = opcode;
            key_next = key_in;
        end
        if (commit)
        begin
            found_next = present;
            case (op_reg)
                uvt_pkg::OP_INSERT:
                begin
                    if (can_insert)
                    begin
                        ctrl.ins    = 1'b1;
                        count_next  = count_reg + 1'b1;
                        status_next = uvt_pkg::ST_DONE;
                    end
                    else
                    begin
                        status_next = uvt_pkg::ST_FULL;
                    end
                end
                uvt_pkg::OP_DELETE:
                begin
                    if (count_reg == '0)
                    begin
                        status_next = uvt_pkg::ST_EMPTY;
                    end
                    else if (!present)
                    begin
                        status_next = uvt_pkg::ST_NOT_FOUND;
                    end
                    else
                    begin
                        ctrl.del    = 1'b1;
                        count_next  = count_reg - 1'b1;
                        status_next = uvt_pkg::ST_DONE;
                    end
                end
                default:
                begin
                    status_next = present ? uvt_pkg::ST_DONE : uvt_pkg::ST_NOT_FOUND;
                end
            endcase
        end
        is_full_next  = CMP_W'(count_next) >= eff_cap;
        is_empty_next = (count_next == '0);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    generate
        for (genvar i = 0; i < DEPTH; i++)
        begin : g_cell
            logic [VALUE_WIDTH-1:0] prev_v;
            logic [VALUE_WIDTH-1:0] next_v;
            if (i == 0)
            begin : g_first
                assign prev_v = key_reg;
            end
            else
            begin : g_mid_prev
                assign prev_v = cell_val[i-1];
            end
            if (i == DEPTH - 1)
            begin : g_last
                assign next_v = cell_val[i];
            end
            else
            begin : g_mid_next
                assign next_v = cell_val[i+1];
            end
            uvt_cell #(
                .VW    (VALUE_WIDTH),
                .CNT_W (CNT_W),
                .IDX   (i)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .key        (key_reg),
                .count      (count_reg),
                .prev_value (prev_v),
                .next_value (next_v),
                .del_sel    (del_sel[i]),
                .value      (cell_val[i]),
                .match      (match_vec[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= uvt_pkg::S_IDLE;
            cap_reg       <= uvt_pkg::CAP_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        status_reg   <= status_next;
        found_reg    <= found_next;
        if (commit)
        begin
            out_count_reg <= count_next;
            is_full_reg   <= is_full_next;
            is_empty_reg  <= is_empty_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign found     = found_reg;
    assign count     = out_count_reg;
    assign is_full   = is_full_reg;
    assign is_empty  = is_empty_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(count_reg) <= CMP_W'(DEPTH))
        else $error("count exceeds table depth");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        commit |-> !(out_valid_reg && out_stall))
        else $error("result overwritten while stalled");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && ctrl.ins) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not grow count");

    a_accept_state: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (state_reg == uvt_pkg::S_IDLE || state_reg == uvt_pkg::S_UPD))
        else $error("transfer taken in compare cycle");
`endif

endmodule
